// ===== rtl/b64dec_pkg.sv =====
// Shared constants and helper functions for the base64 decoder.
// Holds the alphabet decode, the hex digit map and the stream field widths.
// No dependencies.
package b64dec_pkg;

  localparam int CHAR_W          = 8;
  localparam int SEXTET_W        = 6;
  localparam int BYTE_W          = 8;
  localparam int SHOWN_COUNT_W   = 16;
  localparam int DEF_COUNT_WIDTH = 16;
  localparam int OUT_DATA_W      = BYTE_W + SHOWN_COUNT_W;

  localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;  // '='

  // Map one character through the standard alphabet; anything else is zero
  function automatic logic [SEXTET_W-1:0] sextet_of(input logic [CHAR_W-1:0] c);
    logic [SEXTET_W-1:0] s;
    s = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = SEXTET_W'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = SEXTET_W'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = SEXTET_W'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s = 6'd62;
    end else if (c == 8'h2F) begin
      s = 6'd63;
    end
    return s;
  endfunction

  // Upper-case ASCII hex digit of one nibble
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] n);
    logic [BYTE_W-1:0] d;
    if (n < 4'd10) begin
      d = 8'h30 + {4'd0, n};
    end else begin
      d = 8'h37 + {4'd0, n};
    end
    return d;
  endfunction

endpackage

// ===== rtl/base64_decoder_with_hex_output.sv =====
// Streaming base64 decoder with raw or hex byte output.
// Depends on b64dec_pkg for the alphabet map, hex digits and widths.
//
//  channel  | dir | tdata                                  | tlast       | tuser
//  s_axis   | in  | [7:0] char_code                        | last_char   | -
//  m_axis   | out | [7:0] out_value, [23:8] byte_count     | last_result | [0] length_error
//  cfg      | in  | cfg_wdata = hex_output, written when cfg_we is high
//
// Characters are taken one per cycle, while s_axis_tready is high, into the group
// register. The fourth character of a group (or any last_char) hands the group to
// the result buffer, which sends one word per cycle while m_axis_tready is high:
// 3 in raw mode, 6 in hex mode for a full group. That character waits only while
// the previous group is still draining.
// rst is synchronous and clears the group, buffer, counter and mode.
// Stalls on m_axis hold the current word; the input keeps filling the group.
module base64_decoder_with_hex_output #(
  parameter int COUNT_WIDTH = b64dec_pkg::DEF_COUNT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [b64dec_pkg::CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_code
  input  logic                              s_axis_tlast,   // last_char
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [b64dec_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] out_value, [23:8] byte_count
  output logic                              m_axis_tlast,   // last_result
  output logic [0:0]                        m_axis_tuser,   // [0] length_error
  input  logic                              cfg_we,
  input  logic                              cfg_wdata       // hex_output
);
  import b64dec_pkg::*;

  localparam int STORE_W = 3 * SEXTET_W;
  localparam int WORD_W  = 4 * SEXTET_W;

  // Group collection state
  logic [STORE_W-1:0] sextet_store;
  logic [1:0]         group_position;
  logic               pad_third;
  logic               hex_output;

  // Result buffer state
  logic               busy;
  logic [WORD_W-1:0]  word;
  logic [1:0]         last_byte;
  logic               grp_last;
  logic               grp_err;
  logic [1:0]         byte_idx;
  logic               nib;
  logic [COUNT_WIDTH-1:0] bytes_decoded;

  logic [SEXTET_W-1:0] s;
  logic                in_take;
  logic                need_buf;
  logic                out_take;
  logic                grp_final;
  logic [BYTE_W-1:0]   cur_byte;
  logic [BYTE_W-1:0]   out_value;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_shown;

  assign s        = sextet_of(s_axis_tdata);
  assign need_buf = (group_position == 2'd3) || s_axis_tlast;
  assign out_take = busy && m_axis_tready;

  // Final word of the buffered group
  assign grp_final = grp_err || ((byte_idx == last_byte) && (!hex_output || nib));

  assign s_axis_tready = !need_buf || !busy || (out_take && grp_final);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Pick the byte being sent
  always_comb begin
    case (byte_idx)
      2'd0:    cur_byte = word[WORD_W-1 -: BYTE_W];
      2'd1:    cur_byte = word[WORD_W-BYTE_W-1 -: BYTE_W];
      default: cur_byte = word[BYTE_W-1:0];
    endcase
  end

  // Saturating count including the byte being sent
  assign cnt_inc   = (bytes_decoded == {COUNT_WIDTH{1'b1}}) ? bytes_decoded
                                                            : bytes_decoded + 1'b1;
  assign cnt_shown = grp_err ? bytes_decoded : cnt_inc;

  // Drive the output word from the buffer
  always_comb begin
    m_axis_tvalid = busy;
    m_axis_tlast  = grp_err || (grp_last && grp_final);
    m_axis_tuser  = grp_err;
    if (grp_err) begin
      out_value = '0;
    end else if (hex_output) begin
      out_value = nib ? hex_digit(cur_byte[3:0]) : hex_digit(cur_byte[7:4]);
    end else begin
      out_value = cur_byte;
    end
  end

  assign m_axis_tdata[BYTE_W-1:0] = out_value;

  generate
    if (COUNT_WIDTH >= SHOWN_COUNT_W) begin : g_count_wide
      assign m_axis_tdata[OUT_DATA_W-1:BYTE_W] = cnt_shown[SHOWN_COUNT_W-1:0];
    end else begin : g_count_narrow
      assign m_axis_tdata[OUT_DATA_W-1:BYTE_W] =
        {{(SHOWN_COUNT_W-COUNT_WIDTH){1'b0}}, cnt_shown};
    end
  endgenerate

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      hex_output <= 1'b0;
    end else if (cfg_we) begin
      hex_output <= cfg_wdata;
    end
  end

  // Collect sextets; hand the group over on its fourth character or on last
  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_store   <= '0;
      group_position <= '0;
      pad_third      <= 1'b0;
    end else if (in_take) begin
      if (need_buf) begin
        sextet_store   <= '0;
        group_position <= '0;
        pad_third      <= 1'b0;
      end else begin
        sextet_store   <= {sextet_store[STORE_W-SEXTET_W-1:0], s};
        group_position <= group_position + 2'd1;
        if (group_position == 2'd2) begin
          pad_third <= (s_axis_tdata == CHAR_PAD);
        end
      end
    end
  end

  // Load the result buffer and step through its words
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      byte_idx      <= '0;
      nib           <= 1'b0;
      bytes_decoded <= '0;
    end else begin
      // Advance the position on each word taken and the counter once per byte sent
      if (out_take) begin
        if (grp_err || (grp_last && grp_final)) begin
          bytes_decoded <= '0;
        end else if (!hex_output || nib) begin
          bytes_decoded <= cnt_inc;
        end
        if (hex_output && !nib) begin
          nib <= 1'b1;
        end else begin
          nib      <= 1'b0;
          byte_idx <= byte_idx + 2'd1;
        end
        if (grp_final) begin
          busy <= 1'b0;
        end
      end
      // Load wins over release in the same cycle
      if (in_take && need_buf) begin
        busy     <= 1'b1;
        byte_idx <= '0;
        nib      <= 1'b0;
      end
    end
  end

  // Group payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take && need_buf) begin
      word     <= {sextet_store, s};
      grp_last <= s_axis_tlast;
      grp_err  <= (group_position != 2'd3);
      if (!s_axis_tlast) begin
        last_byte <= 2'd2;
      end else if (pad_third) begin
        last_byte <= 2'd0;
      end else if (s_axis_tdata == CHAR_PAD) begin
        last_byte <= 2'd1;
      end else begin
        last_byte <= 2'd2;
      end
    end
  end

endmodule

// ===== rtl/b64dec_checker.sv =====
// Port-level checks for the base64 decoder output stream.
// Depends on b64dec_pkg for widths; bound onto base64_decoder_with_hex_output.
module b64dec_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [b64dec_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                              m_axis_tlast,
  input logic [0:0]                        m_axis_tuser
);
  import b64dec_pkg::*;

  // An error word always closes the string
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("length error word without last flag");

  // An error word carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[BYTE_W-1:0] == '0))
    else $error("length error word with nonzero value");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser)))
    else $error("output word changed while stalled");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind base64_decoder_with_hex_output b64dec_checker u_b64dec_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
